// ===== rtl/core/tpm_pkg.sv =====
package tpm_pkg;

  // Fixed widths of the port fields
  localparam int COUNT_W = 7;
  localparam int COEFF_W = 64;
  localparam int INDEX_W = 6;
  localparam int HALF_W  = 32;

  // Result count after reset
  localparam logic [COUNT_W-1:0] RESULT_COUNT_RESET = 7'd64;

  // Operand codes carried by req_type
  localparam logic REQ_FIRST  = 1'b0;
  localparam logic REQ_SECOND = 1'b1;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_CALC  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

endpackage

// ===== rtl/core/tpm_ram.sv =====
module tpm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/truncated_poly_multiply_unit.sv =====
// Truncated polynomial multiplier. Coefficients of the first operand, then of
// the second, arrive lowest degree first, one item per cycle, into two
// coefficient memories of MAX_COEFFS entries. The item of the second operand
// that carries last_coeff starts the product; coeff_ready stays low until
// the final result is presented. The product is built one result slot at
// a time: for slot k a single pipelined multiply-accumulate (three 32x32
// partial products, a combine stage and an accumulate stage) takes one
// coefficient pair per cycle, and the slot's result waits while result_ready
// is held low. result_count (1..64; 0 reads as 1, values above MAX_COEFFS as
// MAX_COEFFS) sets how many results are emitted, each with its degree and a
// last mark on the final one. All arithmetic wraps modulo 2^COEFF_BITS. No
// memory clearing is needed after reset, and result_count may only be written
// while the block is idle.
module truncated_poly_multiply_unit #(
  parameter int MAX_COEFFS = 64,
  parameter int COEFF_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [tpm_pkg::COUNT_W-1:0]    cfg_write_data,
  input  logic                           coeff_valid,
  output logic                           coeff_ready,
  input  logic                           req_type,
  input  logic [tpm_pkg::COEFF_W-1:0]    coeff_value,
  input  logic                           last_coeff,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [tpm_pkg::COEFF_W-1:0]    product_coeff,
  output logic [tpm_pkg::INDEX_W-1:0]    result_index,
  output logic                           last_result
);

  import tpm_pkg::*;

  localparam int AW = $clog2(MAX_COEFFS);
  localparam int CW = $clog2(MAX_COEFFS + 1);

  state_t state;

  logic [COUNT_W-1:0]    result_count;
  logic [CW-1:0]         len_a;
  logic [CW-1:0]         len_b;
  logic [AW-1:0]         k;
  logic [AW-1:0]         i;
  logic [AW-1:0]         last_slot;
  logic [COEFF_BITS-1:0] acc;

  // Multiply-accumulate pipeline
  logic                  v1, v2, v3;
  logic [2*HALF_W-1:0]   p_ll;
  logic [HALF_W-1:0]     p_lh;
  logic [HALF_W-1:0]     p_hl;
  logic [COEFF_BITS-1:0] prod;

  logic [COEFF_BITS-1:0] a_rdata, b_rdata;
  logic [COEFF_W-1:0]    a_ext, b_ext;
  logic [2*HALF_W-1:0]   mul_ll, mul_lh, mul_hl;
  logic [HALF_W-1:0]     mid_sum;
  logic [2*HALF_W-1:0]   full_sum;

  logic                  take;
  logic                  a_we, b_we;
  logic                  issue;
  logic                  pipe_busy;
  logic                  out_free;
  logic                  emit;
  logic [CW-1:0]         k_ext;
  logic [CW-1:0]         i_ext;
  logic [AW-1:0]         j;
  logic [AW-1:0]         n_last;

  assign coeff_ready = (state == ST_IDLE);
  assign take        = coeff_valid && coeff_ready;
  assign a_we        = take && (req_type == REQ_FIRST) && (len_a < CW'(MAX_COEFFS));
  assign b_we        = take && (req_type == REQ_SECOND) && (len_b < CW'(MAX_COEFFS));

  assign k_ext     = CW'(k);
  assign i_ext     = CW'(i);
  assign j         = k - i;
  assign issue     = (state == ST_CALC) && (i_ext < len_a) && (i <= k);
  assign pipe_busy = v1 || v2 || v3;
  assign out_free  = !result_valid || result_ready;
  assign emit      = (state == ST_EMIT) && out_free;

  // Clamp the configured count into the slot range
  always_comb begin
    if (result_count == '0) begin
      n_last = '0;
    end else if (result_count > COUNT_W'(MAX_COEFFS)) begin
      n_last = AW'(MAX_COEFFS - 1);
    end else begin
      n_last = AW'(result_count - COUNT_W'(1));
    end
  end

  tpm_ram #(
    .WIDTH (COEFF_BITS),
    .DEPTH (MAX_COEFFS)
  ) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (AW'(len_a)),
    .wdata (coeff_value[COEFF_BITS-1:0]),
    .raddr (i),
    .rdata (a_rdata)
  );

  tpm_ram #(
    .WIDTH (COEFF_BITS),
    .DEPTH (MAX_COEFFS)
  ) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (AW'(len_b)),
    .wdata (coeff_value[COEFF_BITS-1:0]),
    .raddr (j),
    .rdata (b_rdata)
  );

  // Split operands into halves for the partial products
  assign a_ext    = COEFF_W'(a_rdata);
  assign b_ext    = COEFF_W'(b_rdata);
  assign mul_ll   = {{HALF_W{1'b0}}, a_ext[HALF_W-1:0]} * {{HALF_W{1'b0}}, b_ext[HALF_W-1:0]};
  assign mul_lh   = {{HALF_W{1'b0}}, a_ext[HALF_W-1:0]} * {{HALF_W{1'b0}}, b_ext[COEFF_W-1:HALF_W]};
  assign mul_hl   = {{HALF_W{1'b0}}, a_ext[COEFF_W-1:HALF_W]} * {{HALF_W{1'b0}}, b_ext[HALF_W-1:0]};
  assign mid_sum  = p_lh + p_hl;
  assign full_sum = p_ll + {mid_sum, {HALF_W{1'b0}}};

  // Advance the multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    p_ll <= mul_ll;
    p_lh <= mul_lh[HALF_W-1:0];
    p_hl <= mul_hl[HALF_W-1:0];
    prod <= full_sum[COEFF_BITS-1:0];
    if (state == ST_SETUP) begin
      acc <= '0;
    end else if (v3) begin
      acc <= acc + prod;
    end
  end

  // Hold the result count register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_count <= RESULT_COUNT_RESET;
    end else if (cfg_write_en) begin
      result_count <= cfg_write_data;
    end
  end

  // Raise result_valid on each emitted item, drop it once the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Sequence loading, per-slot accumulation and emission
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      len_a        <= '0;
      len_b        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (a_we) begin
            len_a <= len_a + CW'(1);
          end
          if (b_we) begin
            len_b <= len_b + CW'(1);
          end
          if (take && (req_type == REQ_SECOND) && last_coeff) begin
            k         <= '0;
            last_slot <= n_last;
            state     <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          // Skip pairs whose second index lies past the second operand
          if (k_ext >= len_b) begin
            i <= AW'(k_ext - len_b + CW'(1));
          end else begin
            i <= '0;
          end
          state <= ST_CALC;
        end
        ST_CALC: begin
          if (!issue) begin
            state <= ST_DRAIN;
          end else begin
            i <= i + AW'(1);
            if ((i == k) || (i_ext + CW'(1) == len_a)) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (!pipe_busy) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            product_coeff <= COEFF_W'(acc);
            result_index  <= INDEX_W'(k);
            last_result   <= (k == last_slot);
            if (k == last_slot) begin
              len_a <= '0;
              len_b <= '0;
              state <= ST_IDLE;
            end else begin
              k     <= k + AW'(1);
              state <= ST_SETUP;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Pipeline is empty whenever new items are taken
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pipe_busy)
    else $error("multiply pipeline busy while idle");

  // Operand lengths never pass the store depth
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (len_a <= CW'(MAX_COEFFS)) && (len_b <= CW'(MAX_COEFFS)))
    else $error("operand length beyond store depth");

  // Every issued pair addresses a loaded second-operand coefficient
  a_pair_in_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> (CW'(j) < len_b))
    else $error("pair issued past second operand");

  // Final slot carries the last mark, and the block returns to idle with it
  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && out_free && (k == last_slot) |=>
      result_valid && last_result && (state == ST_IDLE))
    else $error("final result not marked last");

endmodule

// ===== tb/tb_truncated_poly_multiply_unit.sv =====
`timescale 1ns / 100ps

module tb_truncated_poly_multiply_unit;
  import tpm_pkg::*;

  localparam int TERMS          = 64;
  localparam int STIM_ITEMS     = 470;
  // Block is already idle once its last result is emitted
  localparam int SETTLE_CYCLES  = 20;
  localparam int TAIL_CYCLES    = 100;
  // One result slot walks at most 64 pairs plus the pipeline, so quiet stretches
  // stay far below this limit even with result stalls
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 100;

  typedef struct {
    logic               kind;
    logic [COEFF_W-1:0] value;
    logic               last;
  } coeff_item_t;

  typedef struct {
    logic [COEFF_W-1:0] coeff;
    logic [INDEX_W-1:0] index;
    logic               last;
  } product_term_t;

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               cfg_write_en   = 1'b0;
  logic [COUNT_W-1:0] cfg_write_data = '0;
  logic               coeff_valid    = 1'b0;
  logic               coeff_ready;
  logic               req_type       = REQ_FIRST;
  logic [COEFF_W-1:0] coeff_value    = '0;
  logic               last_coeff     = 1'b0;
  logic               result_valid;
  logic               result_ready   = 1'b0;
  logic [COEFF_W-1:0] product_coeff;
  logic [INDEX_W-1:0] result_index;
  logic               last_result;

  coeff_item_t   pending_coeffs[$];
  product_term_t expected_terms[$];
  coeff_item_t   held_item;
  product_term_t want;

  // Shadow state of the multiplier
  logic [COEFF_W-1:0] lhs_terms[TERMS];
  logic [COEFF_W-1:0] rhs_terms[TERMS];
  int                 lhs_len    = 0;
  int                 rhs_len    = 0;
  logic [COUNT_W-1:0] kept_count = RESULT_COUNT_RESET;

  int mismatch_count = 0;
  int stim_count     = 0;
  int quiet_cycles   = 0;
  logic calm         = 1'b0;

  truncated_poly_multiply_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .coeff_valid    (coeff_valid),
    .coeff_ready    (coeff_ready),
    .req_type       (req_type),
    .coeff_value    (coeff_value),
    .last_coeff     (last_coeff),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .product_coeff  (product_coeff),
    .result_index   (result_index),
    .last_result    (last_result)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Load one accepted coefficient; on a product start, queue the truncated product
  task automatic absorb_coeff(coeff_item_t it);
    logic [COEFF_W-1:0] acc[TERMS];
    int n;
    if (it.kind == REQ_FIRST) begin
      if (lhs_len < TERMS) begin
        lhs_terms[lhs_len] = it.value;
        lhs_len++;
      end
      return;
    end
    if (rhs_len < TERMS) begin
      rhs_terms[rhs_len] = it.value;
      rhs_len++;
    end
    if (!it.last) return;
    n = (kept_count == 0) ? 1 : ((kept_count > TERMS) ? TERMS : int'(kept_count));
    for (int k = 0; k < TERMS; k++) acc[k] = '0;
    for (int i = 0; i < lhs_len; i++) begin
      for (int j = 0; j < rhs_len && i + j < n; j++) begin
        acc[i+j] = acc[i+j] + lhs_terms[i] * rhs_terms[j];
      end
    end
    for (int k = 0; k < n; k++) begin
      expected_terms.push_back('{coeff: acc[k], index: INDEX_W'(k), last: (k == n - 1)});
    end
    lhs_len = 0;
    rhs_len = 0;
  endtask

  function automatic logic [COEFF_W-1:0] pick_coeff();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return COEFF_W'($urandom_range(15));
      3: return COEFF_W'(1) << $urandom_range(COEFF_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_coeff(logic kind, logic [COEFF_W-1:0] value, logic last);
    pending_coeffs.push_back('{kind: kind, value: value, last: last});
    stim_count++;
  endtask

  // Queue a well-formed pair of operands; the final second coefficient starts it
  task automatic push_product(int nf, int ns);
    for (int i = 0; i < nf; i++) push_coeff(REQ_FIRST, pick_coeff(), i == nf - 1);
    for (int j = 0; j < ns; j++) push_coeff(REQ_SECOND, pick_coeff(), j == ns - 1);
  endtask

  // Hold the sender until every result is back and the block is idle
  task automatic settle_idle();
    while (pending_coeffs.size() != 0 || coeff_valid || expected_terms.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [COUNT_W-1:0] v);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    kept_count = v;
  endtask

  // Drive coefficients from the pending queue, idling now and then
  always @(posedge clk) begin
    if (rst) begin
      coeff_valid <= 1'b0;
    end else begin
      if (coeff_valid && coeff_ready) begin
        absorb_coeff(held_item);
      end
      if (!coeff_valid || coeff_ready) begin
        if (pending_coeffs.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
          held_item = pending_coeffs.pop_front();
          coeff_valid <= 1'b1;
          req_type    <= held_item.kind;
          coeff_value <= held_item.value;
          last_coeff  <= held_item.last;
        end else begin
          coeff_valid <= 1'b0;
        end
      end
    end
  end

  // Check each result against the oldest expected term, stalling now and then
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= calm || ($urandom_range(99) >= 6);
      if (result_valid && result_ready) begin
        if (expected_terms.size() == 0) begin
          flag_mismatch($sformatf("unexpected result, index %0d", result_index));
        end else begin
          want = expected_terms.pop_front();
          if (product_coeff !== want.coeff)
            flag_mismatch($sformatf("index %0d: coeff %h, expected %h",
                                    want.index, product_coeff, want.coeff));
          if (result_index !== want.index)
            flag_mismatch($sformatf("result_index %0d, expected %0d",
                                    result_index, want.index));
          if (last_result !== want.last)
            flag_mismatch($sformatf("index %0d: last_result %b, expected %b",
                                    want.index, last_result, want.last));
        end
      end
    end
  end

  // End the run if no item moves on either side for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((coeff_valid && coeff_ready) || (result_valid && result_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int cfg_choices[] = '{64, 2, 100, 127, 7, 63, 1, 33, 0, 5, 64, 48};
    int phase;
    int nf;
    int ns;
    int len;
    logic kind;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Extremes of the coefficient range at the reset result count
    push_coeff(REQ_FIRST, '1, 1'b0);
    push_coeff(REQ_FIRST, COEFF_W'(1), 1'b1);
    push_coeff(REQ_SECOND, '1, 1'b0);
    push_coeff(REQ_SECOND, {1'b1, {(COEFF_W-1){1'b0}}}, 1'b1);
    // Empty first operand gives all-zero terms
    push_coeff(REQ_SECOND, COEFF_W'(5), 1'b1);
    // Last marks on the first operand do nothing; first terms may follow second ones
    push_coeff(REQ_FIRST, COEFF_W'(3), 1'b1);
    push_coeff(REQ_FIRST, COEFF_W'(7), 1'b1);
    push_coeff(REQ_SECOND, COEFF_W'(2), 1'b0);
    push_coeff(REQ_FIRST, COEFF_W'(9), 1'b0);
    push_coeff(REQ_SECOND, COEFF_W'(11), 1'b1);
    settle_idle();

    // Smallest count, zero read as one, and an oversized count
    write_count(COUNT_W'(1));
    push_product(1, 1);
    settle_idle();
    write_count(COUNT_W'(0));
    push_product(1, 1);
    settle_idle();
    write_count(COUNT_W'(127));
    push_product(3, 3);
    settle_idle();

    // Random phases, each under its own result count
    phase = 0;
    while (stim_count < STIM_ITEMS) begin
      write_count(COUNT_W'(phase < cfg_choices.size() ? cfg_choices[phase]
                                                      : $urandom_range(127)));
      calm = (phase >= 4 && phase <= 6);
      for (int p = 0; p < $urandom_range(2, 5); p++) begin
        if (phase == 3 && p == 0) begin
          // Overflow both operands; the mark beyond capacity still starts the product
          nf = TERMS + $urandom_range(1, 3);
          ns = TERMS + $urandom_range(1, 3);
          push_product(nf, ns);
        end else if ($urandom_range(99) < 75) begin
          nf = ($urandom_range(99) < 8) ? $urandom_range(9, TERMS) : $urandom_range(1, 8);
          ns = ($urandom_range(99) < 8) ? $urandom_range(9, TERMS) : $urandom_range(1, 8);
          push_product(nf, ns);
        end else if ($urandom_range(99) < 40) begin
          push_product(0, $urandom_range(1, 4));
        end else begin
          // Interleave both operands with stray last marks on the first
          len = $urandom_range(1, 10);
          for (int i = 0; i < len; i++) begin
            kind = $urandom_range(1) ? REQ_SECOND : REQ_FIRST;
            push_coeff(kind, pick_coeff(), (kind == REQ_FIRST) ? 1'($urandom_range(1)) : 1'b0);
          end
          push_coeff(REQ_SECOND, pick_coeff(), 1'b1);
        end
      end
      settle_idle();
      phase++;
    end
    calm = 1'b0;

    settle_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== truncated_poly_multiply_unit.f =====
rtl/core/tpm_pkg.sv
rtl/core/tpm_ram.sv
rtl/core/truncated_poly_multiply_unit.sv
tb/tb_truncated_poly_multiply_unit.sv
